>>> src/xcrc_pkg.sv
// Shared types and constants for the XMODEM CRC receiver.
// Holds the event and result transfer structs, operation codes and protocol
// characters; no dependencies.
package xcrc_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;

    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_SUB  = 8'h1A;
    localparam logic [7:0] CH_POLL = 8'h43;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_REPLY   = 1'b1;

    localparam int         HEADER_BYTES = 3;
    localparam int         OFFSET_W     = 10;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } event_t;

    typedef struct packed {
        logic                result_kind;
        logic [7:0]          payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic [7:0]          reply_byte;
        logic                block_good;
        logic                block_end;
        logic                transfer_done;
        logic                header_error;
    } result_t;

endpackage

>>> src/xcrc_parser.sv
// Frame parser and receiver state: position counter, running CRC-16 and
// transfer flags, with the result for each accepted event. Uses xcrc_pkg.
module xcrc_parser #(
    parameter int LONG_PAYLOAD_BYTES  = 1024,
    parameter int SHORT_PAYLOAD_BYTES = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  xcrc_pkg::event_t item,
    output logic             res_valid,
    output xcrc_pkg::result_t res
);
    import xcrc_pkg::*;

    localparam int MAX_PAYLOAD = (LONG_PAYLOAD_BYTES > SHORT_PAYLOAD_BYTES) ?
                                 LONG_PAYLOAD_BYTES : SHORT_PAYLOAD_BYTES;
    localparam int POS_RAW = $clog2(MAX_PAYLOAD + HEADER_BYTES + 3);
    localparam int POS_W   = (POS_RAW > OFFSET_W) ? POS_RAW : OFFSET_W;

    localparam logic [POS_W-1:0] POS_HDR       = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LONG_END  = POS_W'(HEADER_BYTES + LONG_PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_SHORT_END = POS_W'(HEADER_BYTES + SHORT_PAYLOAD_BYTES);

    logic [POS_W-1:0] position_reg, position_next;
    logic             long_block_reg, long_block_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic             data_started_reg, data_started_next;
    logic             active_reg, active_next;

    logic [POS_W-1:0] crc_pos;
    logic [POS_W-1:0] pos_diff;
    logic [15:0]      crc_byte_out;

    // Byte-wise CRC-16/XMODEM: eight shift steps on 16 bits
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign crc_pos      = long_block_reg ? POS_LONG_END : POS_SHORT_END;
    assign pos_diff     = position_reg - POS_HDR;
    assign crc_byte_out = crc_update(crc_reg, item.rx_byte);

    always_comb
    begin
        position_next     = position_reg;
        long_block_next   = long_block_reg;
        crc_next          = crc_reg;
        crc_high_next     = crc_high_reg;
        data_started_next = data_started_reg;
        active_next       = active_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.result_kind   = KIND_REPLY;

        case (item.operation)
            OP_START:
            begin
                position_next     = '0;
                crc_next          = '0;
                crc_high_next     = '0;
                data_started_next = 1'b0;
                active_next       = 1'b1;
                res_valid         = 1'b1;
                res.reply_byte    = CH_POLL;
            end
            OP_POLL:
            begin
                if (active_reg && !data_started_reg)
                begin
                    res_valid      = 1'b1;
                    res.reply_byte = CH_POLL;
                end
            end
            OP_BYTE:
            begin
                if (active_reg)
                begin
                    data_started_next = 1'b1;
                    if (position_reg == '0)
                    begin
                        if (item.rx_byte == CH_STX || item.rx_byte == CH_SOH)
                        begin
                            long_block_next = (item.rx_byte == CH_STX);
                            crc_next        = '0;
                            position_next   = POS_W'(1);
                        end
                        else if (item.rx_byte == CH_EOT || item.rx_byte == CH_SUB)
                        begin
                            active_next       = 1'b0;
                            res_valid         = 1'b1;
                            res.reply_byte    = CH_ACK;
                            res.transfer_done = 1'b1;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.reply_byte   = CH_NAK;
                            res.header_error = 1'b1;
                        end
                    end
                    else if (position_reg < POS_HDR)
                    begin
                        position_next = position_reg + POS_W'(1);
                    end
                    else if (position_reg < crc_pos)
                    begin
                        crc_next           = crc_byte_out;
                        position_next      = position_reg + POS_W'(1);
                        res_valid          = 1'b1;
                        res.result_kind    = KIND_PAYLOAD;
                        res.payload_byte   = item.rx_byte;
                        res.payload_offset = pos_diff[OFFSET_W-1:0];
                    end
                    else if (position_reg == crc_pos)
                    begin
                        crc_high_next = item.rx_byte;
                        position_next = position_reg + POS_W'(1);
                    end
                    else
                    begin
                        position_next  = '0;
                        crc_next       = '0;
                        res_valid      = 1'b1;
                        res.block_end  = 1'b1;
                        res.block_good = ({crc_high_reg, item.rx_byte} == crc_reg);
                        res.reply_byte = res.block_good ? CH_ACK : CH_NAK;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            long_block_reg   <= 1'b0;
            crc_reg          <= '0;
            crc_high_reg     <= '0;
            data_started_reg <= 1'b0;
            active_reg       <= 1'b0;
        end
        else if (take)
        begin
            position_reg     <= position_next;
            long_block_reg   <= long_block_next;
            crc_reg          <= crc_next;
            crc_high_reg     <= crc_high_next;
            data_started_reg <= data_started_next;
            active_reg       <= active_next;
        end
    end

endmodule

>>> src/xcrc_out_reg.sv
// Result register between the parser and the result channel.
// Holds one result while the consumer stalls. Uses xcrc_pkg.
module xcrc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  xcrc_pkg::result_t load_data,
    input  logic              stall,
    output logic              free,
    output logic              valid,
    output xcrc_pkg::result_t data
);
    import xcrc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Slot can take a new result when empty or being drained this cycle
    assign free       = !valid_reg || !stall;
    assign valid_next = load ? 1'b1 : (valid_reg && stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> src/xmodem_crc_receiver.sv
// XMODEM / XMODEM-1K receiver with CRC-16: one event per transfer, result
// in the cycle after acceptance. Throughput is one event per cycle; the only
// limit is the single result register, which stalls events while it holds
// an untaken result. Reset (rst_n low, asynchronous) leaves the receiver
// inactive with position, CRC and flags cleared and the result slot empty.
// Depends on xcrc_pkg, xcrc_parser and xcrc_out_reg.
module xmodem_crc_receiver #(
    parameter int LONG_PAYLOAD_BYTES  = 1024,
    parameter int SHORT_PAYLOAD_BYTES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              event_valid,
    output logic              event_stall,
    input  xcrc_pkg::event_t  event_data,
    output logic              result_valid,
    input  logic              result_stall,
    output xcrc_pkg::result_t result_data
);
    import xcrc_pkg::*;

    logic    take;
    logic    slot_free;
    logic    res_valid;
    result_t res;

    // Hold off events only while the result register is full and stalled;
    // an event that gives no result still needs the slot, which keeps the
    // acceptance rule independent of the event's contents.
    assign event_stall = !slot_free;
    assign take        = event_valid && slot_free;

    // Parser: tracks position, CRC and flags, updated only on accepted transfers
    xcrc_parser #(
        .LONG_PAYLOAD_BYTES  (LONG_PAYLOAD_BYTES),
        .SHORT_PAYLOAD_BYTES (SHORT_PAYLOAD_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (event_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load only when the accepted event produced a result
    xcrc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .load_data (res),
        .stall     (result_stall),
        .free      (slot_free),
        .valid     (result_valid),
        .data      (result_data)
    );

endmodule
